// File: hdl/shamh_pkg.sv
`default_nettype none
package shamh_pkg;

	// Message length counter width; the length field in the last block is always 64 bits.
	localparam int LEN_BITS = 64;

	localparam int BUF_WORDS   = 16;
	localparam int CHAIN_WORDS = 8;
	localparam int ROUNDS      = 64;

	// Word slots of the length field in the final block.
	localparam logic [3:0] LEN_HI_WORD = 4'd14;
	localparam logic [3:0] LEN_LO_WORD = 4'd15;

	localparam logic [31:0] INIT_HASH [CHAIN_WORDS] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// Controls from the sequencer to the round datapath.
	typedef struct packed {
		logic       load;
		logic       round;
		logic [5:0] rnd;
	} core_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/shamh_ram.sv
`default_nettype none
module shamh_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// File: hdl/shamh_core.sv
`default_nettype none
module shamh_core (
	input  wire logic                  clk,
	input  wire shamh_pkg::core_ctrl_t ctrl,
	input  wire logic [31:0]           load_word,
	input  wire logic [31:0]           buf_word,
	input  wire logic [2:0]            ff_sel,
	output logic      [31:0]           ff_word
);

	import shamh_pkg::*;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [31:0] sched;
	logic [31:0] w_cur;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] big0;
	logic [31:0] big1;
	logic [31:0] choose;
	logic [31:0] major;

	// Window w_q[k] holds w[r-16+k]; extend the schedule from its taps.
	always_comb begin
		sched = (rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10)) + w_q[9]
			+ (rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3)) + w_q[0];
		w_cur  = (ctrl.rnd < 6'd16) ? buf_word : sched;
		big1   = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		big0   = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1     = v_q[7] + big1 + choose + ROUND_K[ctrl.rnd] + w_cur;
		t2     = big0 + major;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			for (int k = 0; k < 7; k++) begin
				v_q[k] <= v_q[k + 1];
			end
			v_q[7] <= load_word;
		end else if (ctrl.round) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int k = 0; k < 15; k++) begin
				w_q[k] <= w_q[k + 1];
			end
			w_q[15] <= w_cur;
		end
	end

	assign ff_word = v_q[ff_sel];

endmodule
`default_nettype wire

// File: hdl/sha256_message_hasher.sv
`default_nettype none
// SHA-256 message hasher, one message byte per input item.
// Input channel (in_valid / in_stall / in_item): an item is taken when in_valid is high and
// in_stall is low. An item carries a byte (has_byte) and/or the end mark (end_of_message);
// an item with neither does nothing, an end item without a byte closes the message as is.
// Plain byte items are taken back to back. The item that fills a 64-byte block stalls the
// input while the block is compressed: chain reads, 64 rounds on the one-round-per-cycle
// datapath, then chain updates.
// End of message: the 0x80 marker is placed, the rest of the block buffer is zeroed, the
// length is written and the block is compressed. When the length does not fit, the marker
// block is first zeroed to its end and compressed, then a fresh block is zeroed before the
// length goes in.
// Output channel (out_valid / out_stall / out_item): eight digest words, index 0 first,
// last_word set on the eighth. Each word goes through memory read, capture and hand-off,
// and holds in the output register while out_stall is high; input stays stalled until
// the last word is taken, then the initial hash values are back in place.
// Configuration (cfg_valid / cfg_ready / cfg_data): feed_forward, always ready; 1 adds the
// round result to the chaining words, 0 replaces them.
// Reset (arst_n low, asynchronous): feed_forward returns to 1, the byte counters clear and
// the chaining memory reads as the initial values through per-word valid bits.
module sha256_message_hasher (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire shamh_pkg::in_item_t  in_item,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output shamh_pkg::out_item_t      out_item,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic                 cfg_data
);

	import shamh_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE     = 11'b000_0000_0001,
		ST_PAD      = 11'b000_0000_0010,
		ST_ZERO     = 11'b000_0000_0100,
		ST_LEN_HI   = 11'b000_0000_1000,
		ST_LEN_LO   = 11'b000_0001_0000,
		ST_LOAD     = 11'b000_0010_0000,
		ST_ROUND    = 11'b000_0100_0000,
		ST_FF       = 11'b000_1000_0000,
		ST_OUT_RD   = 11'b001_0000_0000,
		ST_OUT_CAP  = 11'b010_0000_0000,
		ST_OUT_HOLD = 11'b100_0000_0000
	} state_t;

	state_t              state_q;
	state_t              ret_q;
	logic                feed_forward_q;
	logic [5:0]          offset_q;
	logic [LEN_BITS-1:0] len_q;
	logic [31:0]         word_q;
	logic [3:0]          cnt_q;
	logic [5:0]          rnd_q;
	logic [4:0]          ptr_q;
	logic                extra_q;
	logic [2:0]          out_idx_q;
	logic                out_valid_q;
	out_item_t           out_q;
	logic [7:0]          chain_vld_q;
	logic                chain_vld_s1;
	logic [2:0]          chain_raddr_s1;

	logic                accept;
	logic [1:0]          pos;
	logic [31:0]         new_word;
	logic [31:0]         pad_word;
	logic [63:0]         len64;
	logic [4:0]          zero_limit;

	logic                buf_we;
	logic [3:0]          buf_waddr;
	logic [31:0]         buf_wdata;
	logic [3:0]          buf_raddr;
	logic [31:0]         buf_rdata;

	logic                ch_we;
	logic [2:0]          ch_waddr;
	logic [31:0]         ch_wdata;
	logic [2:0]          ch_raddr;
	logic [31:0]         ch_rdata;
	logic [31:0]         ch_word;

	core_ctrl_t          core_ctrl;
	logic [31:0]         ff_word;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign pos       = offset_q[1:0];
	assign len64     = 64'(len_q);
	assign zero_limit = extra_q ? 5'd15 : 5'd13;

	// Insert the byte at its big-endian place in the word being packed.
	always_comb begin
		new_word = word_q;
		case (pos)
			2'd0:    new_word[31:24] = in_item.msg_byte;
			2'd1:    new_word[23:16] = in_item.msg_byte;
			2'd2:    new_word[15:8]  = in_item.msg_byte;
			default: new_word[7:0]   = in_item.msg_byte;
		endcase
	end

	// Keep the bytes already packed, then the marker, then zeros.
	always_comb begin
		case (pos)
			2'd0:    pad_word = 32'h8000_0000;
			2'd1:    pad_word = {word_q[31:24], 24'h80_0000};
			2'd2:    pad_word = {word_q[31:16], 16'h8000};
			default: pad_word = {word_q[31:8], 8'h80};
		endcase
	end

	// Block buffer port: byte packing, padding, zeroing and length writes; one word a round for reads.
	always_comb begin
		buf_we    = 1'b0;
		buf_waddr = offset_q[5:2];
		buf_wdata = new_word;
		unique case (state_q)
			ST_IDLE: begin
				buf_we = accept && in_item.has_byte && (pos == 2'd3);
			end
			ST_PAD: begin
				buf_we    = 1'b1;
				buf_wdata = pad_word;
			end
			ST_ZERO: begin
				buf_we    = (ptr_q <= zero_limit);
				buf_waddr = ptr_q[3:0];
				buf_wdata = '0;
			end
			ST_LEN_HI: begin
				buf_we    = 1'b1;
				buf_waddr = LEN_HI_WORD;
				buf_wdata = len64[63:32];
			end
			ST_LEN_LO: begin
				buf_we    = 1'b1;
				buf_waddr = LEN_LO_WORD;
				buf_wdata = len64[31:0];
			end
			default: begin
				buf_we = 1'b0;
			end
		endcase
	end

	// Prefetch the next round's word; word 0 is read while the chain loads.
	assign buf_raddr = (state_q == ST_ROUND) ? (rnd_q[3:0] + 4'd1) : 4'd0;

	// Chaining memory: unwritten-since-message-start words read as the initial values.
	assign ch_raddr = (state_q == ST_LOAD || state_q == ST_FF) ? cnt_q[2:0] : out_idx_q;
	assign ch_word  = chain_vld_s1 ? ch_rdata : INIT_HASH[chain_raddr_s1];
	assign ch_we    = (state_q == ST_FF) && (cnt_q != 4'd0);
	assign ch_waddr = 3'(cnt_q - 4'd1);
	assign ch_wdata = feed_forward_q ? (ch_word + ff_word) : ff_word;

	assign core_ctrl.load  = (state_q == ST_LOAD) && (cnt_q != 4'd0);
	assign core_ctrl.round = (state_q == ST_ROUND);
	assign core_ctrl.rnd   = rnd_q;

	shamh_ram #(
		.DEPTH(BUF_WORDS),
		.WIDTH(32)
	) u_buf_ram (
		.clk  (clk),
		.we   (buf_we),
		.waddr(buf_waddr),
		.wdata(buf_wdata),
		.raddr(buf_raddr),
		.rdata(buf_rdata)
	);

	shamh_ram #(
		.DEPTH(CHAIN_WORDS),
		.WIDTH(32)
	) u_chain_ram (
		.clk  (clk),
		.we   (ch_we),
		.waddr(ch_waddr),
		.wdata(ch_wdata),
		.raddr(ch_raddr),
		.rdata(ch_rdata)
	);

	shamh_core u_core (
		.clk      (clk),
		.ctrl     (core_ctrl),
		.load_word(ch_word),
		.buf_word (buf_rdata),
		.ff_sel   (ch_waddr),
		.ff_word  (ff_word)
	);

	// Payload registers: packed word and read-side tracking.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && in_item.has_byte) begin
			word_q <= new_word;
		end
		chain_raddr_s1 <= ch_raddr;
		chain_vld_s1   <= chain_vld_q[ch_raddr];
		if (state_q == ST_OUT_CAP) begin
			out_q.digest_word <= ch_word;
			out_q.word_index  <= out_idx_q;
			out_q.last_word   <= (out_idx_q == 3'd7);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			ret_q          <= ST_IDLE;
			feed_forward_q <= 1'b1;
			offset_q       <= '0;
			len_q          <= '0;
			cnt_q          <= '0;
			rnd_q          <= '0;
			ptr_q          <= '0;
			extra_q        <= 1'b0;
			out_idx_q      <= '0;
			out_valid_q    <= 1'b0;
			chain_vld_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				feed_forward_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_item.has_byte) begin
							offset_q <= offset_q + 6'd1;
							len_q    <= len_q + LEN_BITS'(8);
							if (offset_q == 6'd63) begin
								// Block full: compress, then pad if the message ends here.
								cnt_q   <= '0;
								ret_q   <= in_item.end_of_message ? ST_PAD : ST_IDLE;
								state_q <= ST_LOAD;
							end else if (in_item.end_of_message) begin
								state_q <= ST_PAD;
							end
						end else if (in_item.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					extra_q <= (offset_q[5:3] == 3'b111);
					ptr_q   <= {1'b0, offset_q[5:2]} + 5'd1;
					state_q <= ST_ZERO;
				end
				ST_ZERO: begin
					if (ptr_q <= zero_limit) begin
						ptr_q <= ptr_q + 5'd1;
					end else if (extra_q) begin
						// No room for the length: compress this block, then zero a fresh one.
						extra_q <= 1'b0;
						ptr_q   <= '0;
						cnt_q   <= '0;
						ret_q   <= ST_ZERO;
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_LEN_HI;
					end
				end
				ST_LEN_HI: begin
					state_q <= ST_LEN_LO;
				end
				ST_LEN_LO: begin
					offset_q  <= '0;
					len_q     <= '0;
					out_idx_q <= '0;
					cnt_q     <= '0;
					ret_q     <= ST_OUT_RD;
					state_q   <= ST_LOAD;
				end
				ST_LOAD: begin
					if (cnt_q == 4'd8) begin
						rnd_q   <= '0;
						state_q <= ST_ROUND;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						cnt_q   <= '0;
						state_q <= ST_FF;
					end
				end
				ST_FF: begin
					if (cnt_q != 4'd0) begin
						chain_vld_q[ch_waddr] <= 1'b1;
					end
					if (cnt_q == 4'd8) begin
						state_q <= ret_q;
					end else begin
						cnt_q <= cnt_q + 4'd1;
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_CAP;
				end
				ST_OUT_CAP: begin
					// Word read out: drop it back to the initial value for the next message.
					chain_vld_q[out_idx_q] <= 1'b0;
					out_valid_q            <= 1'b1;
					state_q                <= ST_OUT_HOLD;
				end
				ST_OUT_HOLD: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						out_idx_q   <= out_idx_q + 3'd1;
						state_q     <= (out_idx_q == 3'd7) ? ST_IDLE : ST_OUT_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_out_only_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == ST_OUT_HOLD))
		else $error("digest word presented outside the hand-off state");

	a_no_input_during_output: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !out_valid)
		else $error("input item accepted while a digest word is pending");

	a_rounds_then_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && rnd_q == 6'd63) |=> (state_q == ST_FF && cnt_q == 4'd0))
		else $error("last round not followed by the chain update");

	a_handoff_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |=> (state_q == ST_OUT_RD || state_q == ST_IDLE))
		else $error("digest hand-off did not advance");

endmodule
`default_nettype wire
